// File: rtl/sts_pkg.sv
// Package with shared types and constants of the sphere-trace hit engine.
`timescale 1ns / 1ps
package sts_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_NEXT,
      ST_SQ,
      ST_RSTART,
      ST_ROOT,
      ST_EVAL,
      ST_MOVE,
      ST_FINISH
   } sts_state_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [14:0]        radius;
   } sts_sphere_type;

   // Request codes.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_RAY   = 1'b1;

   // Register indexes.
   localparam logic [1:0] REG_HIT_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_MAX_DISTANCE  = 2'd1;
   localparam logic [1:0] REG_SPHERE_COUNT  = 2'd2;

   localparam logic [14:0] HIT_THRESHOLD_RESET = 15'd13;
   localparam logic [14:0] MAX_DISTANCE_RESET  = 15'd2560;
   localparam logic [3:0]  SPHERE_COUNT_RESET  = 4'd0;

   // Evaluations per ray before it is given up as a miss.
   localparam logic [7:0] MARCH_LIMIT = 8'd200;
   // Step of an empty scene, 1000.0 in signed Q10.8.
   localparam logic signed [18:0] EMPTY_STEP = 19'sd256000;
   // Half of one Q1.14 unit, for rounding the move.
   localparam logic signed [35:0] ROUND_HALF = 36'sd8192;

endpackage

// File: rtl/sts_req_if.sv
// Request channel interface: sphere writes and ray casts.
`timescale 1ns / 1ps
interface sts_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [2:0]         sphere_index;
   logic signed [15:0] centre_x;
   logic signed [15:0] centre_y;
   logic signed [15:0] centre_z;
   logic [14:0]        radius;
   logic signed [15:0] origin_x;
   logic signed [15:0] origin_y;
   logic signed [15:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;

   modport source (output valid, req_type, sphere_index, centre_x, centre_y, centre_z,
                   radius, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, req_type, sphere_index, centre_x, centre_y, centre_z,
                 radius, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

// File: rtl/sts_rsp_if.sv
// Response channel interface: one hit flag per ray.
`timescale 1ns / 1ps
interface sts_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

// File: rtl/sts_cell.sv
// One cell of the rotating sphere ring: holds a sphere entry.
`timescale 1ns / 1ps
module sts_cell
   import sts_pkg::*;
(
   input  logic           clock,
   input  logic           shift,
   input  logic           load,
   input  sts_sphere_type load_data,
   input  sts_sphere_type next_data,
   output sts_sphere_type data
);

   sts_sphere_type data_ff;

   // Entries are undefined until written, so there is no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end else if (shift) begin
         data_ff <= next_data;
      end
   end

   assign data = data_ff;

endmodule

// File: rtl/sts_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`timescale 1ns / 1ps
module sts_isqrt
   import sts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [33:0] operand,
   output logic        done,
   output logic [16:0] root
);

   logic [34:0] rem_ff, rem_in;
   logic [34:0] res_ff, res_in;
   logic [4:0]  k_ff, k_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] bitv;
   logic [34:0] trial;

   always_comb begin
      bitv    = 35'(1) << {k_ff, 1'b0};
      trial   = res_ff + bitv;
      rem_in  = rem_ff;
      res_in  = res_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, operand};
         res_in  = '0;
         k_in    = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bitv;
         end else begin
            res_in = res_ff >> 1;
         end
         k_in = k_ff - 5'd1;
         if (k_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      k_ff   <= k_in;
   end

   assign done = done_ff;
   assign root = res_ff[16:0];

endmodule

// File: rtl/sphere_trace_ray_hit.sv
// Top level of the sphere-trace hit engine: ring of sphere cells, sequencer and registers.
`timescale 1ns / 1ps
// The engine traces one ray at a time against up to MAX_SPHERES spheres held in a ring
// of cells. A write transaction stores one sphere into its cell; a ray transaction produces
// one hit transaction when the march ends. Each march step rotates the ring once around:
// every valid sphere passes a select step, squaring on the shared multiplier with a final
// accumulate, a start step and the bit-serial square root, after which the minimum is taken;
// every entry beyond sphere_count is only rotated past in the select step, and the check,
// the evaluation and the move along the ray follow. A finished result waits in the output
// register while the next request is taken.
module sphere_trace_ray_hit
   import sts_pkg::*;
#(
   parameter int MAX_SPHERES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   sts_req_if.sink     req_ch,
   sts_rsp_if.source   rsp_ch
);

   localparam int CNT_W = $clog2(MAX_SPHERES + 1);

   // Configuration registers.
   logic [14:0] thr_ff;
   logic [14:0] max_ff;
   logic [3:0]  cnt_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= HIT_THRESHOLD_RESET;
         max_ff <= MAX_DISTANCE_RESET;
         cnt_ff <= SPHERE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_HIT_THRESHOLD: thr_ff <= csr_pwdata[14:0];
            REG_MAX_DISTANCE:  max_ff <= csr_pwdata[14:0];
            REG_SPHERE_COUNT:  cnt_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HIT_THRESHOLD: csr_prdata = {17'd0, thr_ff};
         REG_MAX_DISTANCE:  csr_prdata = {17'd0, max_ff};
         REG_SPHERE_COUNT:  csr_prdata = {28'd0, cnt_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Counts beyond the table size are clamped to the table size.
   logic [CNT_W-1:0] valid_cnt;
   assign valid_cnt = (int'(cnt_ff) > MAX_SPHERES) ? CNT_W'(MAX_SPHERES) : CNT_W'(cnt_ff);

   // Sequencer state.
   sts_state_type state_ff, state_in;
   logic               req_accept;
   logic               ring_shift;
   logic               root_start;
   logic               root_done;
   logic [16:0]        root;

   logic signed [15:0] pos_ff [3];
   logic signed [15:0] dir_ff [3];
   logic [19:0]        walked_ff;
   logic [7:0]         iter_ff;
   logic signed [18:0] best_ff;
   logic [1:0]         sub_ff;
   logic [CNT_W-1:0]   vis_ff;
   logic signed [35:0] prod_ff;
   logic [33:0]        acc_ff;
   logic               hit_ff;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;

   // The ring of cells; cell zero is the head that the datapath reads.
   sts_sphere_type cell_data [MAX_SPHERES];
   sts_sphere_type wr_data;

   assign wr_data = '{cx: req_ch.centre_x, cy: req_ch.centre_y, cz: req_ch.centre_z,
                      radius: req_ch.radius};

   for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
      sts_cell u_cell (
         .clock     (clock),
         .shift     (ring_shift),
         .load      (req_accept && req_ch.req_type == REQ_WRITE
                     && int'(req_ch.sphere_index) == i),
         .load_data (wr_data),
         .next_data (cell_data[(i + 1) % MAX_SPHERES]),
         .data      (cell_data[i])
      );
   end

   sts_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (acc_ff),
      .done    (root_done),
      .root    (root)
   );

   // Shared multiplier: squared coordinate differences, then direction times step.
   sts_sphere_type     head;
   logic signed [15:0] head_c;
   logic signed [16:0] diff;
   logic signed [16:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [35:0] mul_p;
   logic signed [17:0] sphere_gap;
   logic signed [21:0] delta;
   logic signed [22:0] moved;
   logic signed [15:0] moved_sat;

   assign head = cell_data[0];

   always_comb begin
      unique case (sub_ff)
         2'd0:    head_c = head.cx;
         2'd1:    head_c = head.cy;
         default: head_c = head.cz;
      endcase
      diff = 17'(pos_ff[sub_ff]) - 17'(head_c);
      if (state_ff == ST_SQ) begin
         mul_a = diff;
         mul_b = 19'(diff);
      end else begin
         mul_a = 17'(dir_ff[sub_ff]);
         mul_b = best_ff;
      end
      mul_p = 36'(mul_a) * 36'(mul_b);
      sphere_gap = $signed({1'b0, root}) - $signed({3'b000, head.radius});
      // Adding the rounding half and shifting arithmetically rounds to nearest, ties upward.
      delta = 22'((prod_ff + ROUND_HALF) >>> 14);
      moved = 23'(pos_ff[sub_ff - 2'd1]) + 23'(delta);
      if (moved > 23'sd32767) begin
         moved_sat = 16'sh7fff;
      end else if (moved < -23'sd32768) begin
         moved_sat = -16'sh8000;
      end else begin
         moved_sat = 16'(moved);
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_ch.req_type == REQ_RAY) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (iter_ff < MARCH_LIMIT && walked_ff < {5'd0, max_ff}) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_NEXT: begin
            if (int'(vis_ff) == MAX_SPHERES) begin
               state_in = ST_EVAL;
            end else if (vis_ff < valid_cnt) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (sub_ff == 2'd3) begin
               state_in = ST_RSTART;
            end
         end
         ST_RSTART: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_EVAL: begin
            if (best_ff < $signed({4'd0, thr_ff})) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (sub_ff == 2'd3) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      root_start   = (state_ff == ST_RSTART);
      ring_shift   = 1'b0;
      unique case (state_ff)
         ST_NEXT: ring_shift = (int'(vis_ff) != MAX_SPHERES) && !(vis_ff < valid_cnt);
         ST_ROOT: ring_shift = root_done;
         default: ring_shift = 1'b0;
      endcase
   end

   assign req_accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            pos_ff[0] <= req_ch.origin_x;
            pos_ff[1] <= req_ch.origin_y;
            pos_ff[2] <= req_ch.origin_z;
            dir_ff[0] <= req_ch.dir_x;
            dir_ff[1] <= req_ch.dir_y;
            dir_ff[2] <= req_ch.dir_z;
            walked_ff <= '0;
            iter_ff   <= '0;
            hit_ff    <= 1'b0;
         end
         ST_CHECK: begin
            best_ff <= EMPTY_STEP;
            vis_ff  <= '0;
            sub_ff  <= '0;
            iter_ff <= iter_ff + 8'd1;
         end
         ST_NEXT: begin
            sub_ff <= '0;
            if (ring_shift) begin
               vis_ff <= vis_ff + CNT_W'(1);
            end
         end
         ST_SQ: begin
            sub_ff <= sub_ff + 2'd1;
            if (sub_ff != 2'd3) begin
               prod_ff <= mul_p;
            end
            if (sub_ff == 2'd0) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_ff + prod_ff[33:0];
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               vis_ff <= vis_ff + CNT_W'(1);
               if (19'(sphere_gap) < best_ff) begin
                  best_ff <= 19'(sphere_gap);
               end
            end
         end
         ST_EVAL: begin
            sub_ff <= '0;
            if (best_ff < $signed({4'd0, thr_ff})) begin
               hit_ff <= 1'b1;
            end else begin
               walked_ff <= walked_ff + {1'b0, best_ff};
            end
         end
         ST_MOVE: begin
            sub_ff <= sub_ff + 2'd1;
            if (sub_ff != 2'd3) begin
               prod_ff <= mul_p;
            end
            if (sub_ff != 2'd0) begin
               pos_ff[sub_ff - 2'd1] <= moved_sat;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_hit_ff <= hit_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hit   = rsp_hit_ff;

endmodule
